// File: sv/lpr_pkg.sv
// shared types and constants for the line pixel rasterizer
`default_nettype none

package lpr_pkg;

   localparam int SCREEN_WIDTH  = 240;
   localparam int SCREEN_HEIGHT = 320;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic signed [11:0] x_start;
      logic signed [11:0] y_start;
      logic signed [11:0] x_end;
      logic signed [11:0] y_end;
      logic        [15:0] line_color;
   } req_type;

   typedef struct packed {
      logic [7:0]  native_x;
      logic [8:0]  native_y;
      logic [15:0] pixel_color;
      logic        visible;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/line_pixel_rasterizer.sv
// line rasterizer: bresenham walk, clip to the logical screen, rotate to panel coordinates
//
// req channel: a start transaction loads both endpoints and the color and gives no
// result; each tick transaction while a line is active gives one pixel on rsp.
// a tick with no active line gives nothing; a start during a line replaces it.
// csr port: csr_write_enable writes the 2-bit rotation; the user must do this only
// while the block is idle, which the block itself does not enforce. a transaction is
// held in the input register; its pixel is registered into the rsp register.
// throughput: one transaction per cycle unless a stall holds it; each tick costs one
// error update and one increment in the walk stage, so pixels stream out back to back.
// stalls: the rsp register holds its pixel while rsp_stall is high; the input register
// then takes a transaction only while empty, and req_stall is high once it is full.
// reset: synchronous, clears the active-line flag, rotation and both valid flags.
`default_nettype none

module line_pixel_rasterizer (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   input  wire lpr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  wire             rsp_stall,
   output lpr_pkg::rsp_type rsp_data,
   input  wire             csr_write_enable,
   input  wire [1:0]       csr_write_data
);
   import lpr_pkg::*;

   // input register
   logic    stage_valid_ff, stage_valid_in;
   req_type stage_ff;

   // line state
   logic               busy_ff, busy_in;
   logic               steep_ff, steep_in;
   logic signed [11:0] major_pos_ff, major_pos_in;
   logic signed [11:0] major_end_ff, major_end_in;
   logic signed [11:0] minor_pos_ff, minor_pos_in;
   logic               minor_dir_ff, minor_dir_in;
   logic        [12:0] major_span_ff, major_span_in;
   logic        [12:0] minor_span_ff, minor_span_in;
   logic signed [13:0] error_ff, error_in;
   logic        [15:0] color_ff, color_in;
   logic        [1:0]  rotation_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic advance;
   logic take_req;
   logic is_start;
   logic is_pixel;

   // start setup
   logic signed [12:0] dx, dy;
   logic        [12:0] adx, ady;
   logic               steep;
   logic signed [11:0] sax, say, sbx, sby;
   logic               swap_ends;
   logic signed [11:0] fax, fay, fby;

   // pixel
   logic signed [11:0] lx, ly;
   logic        [11:0] lw, lh;
   logic               vis;
   logic               fin;
   logic        [11:0] nx, ny;
   logic signed [13:0] err_sub;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign take_req = req_valid && !req_stall;
   assign req_stall = stage_valid_ff && !advance;

   assign stage_valid_in = take_req || (stage_valid_ff && !advance);

   assign is_start = stage_valid_ff && advance && (stage_ff.operation == OP_START);
   assign is_pixel = stage_valid_ff && advance && (stage_ff.operation == OP_TICK) && busy_ff;

   // orient the line so the major axis runs upward
   always_comb begin
      dx    = 13'(stage_ff.x_end) - 13'(stage_ff.x_start);
      dy    = 13'(stage_ff.y_end) - 13'(stage_ff.y_start);
      adx   = dx[12] ? 13'(-dx) : 13'(dx);
      ady   = dy[12] ? 13'(-dy) : 13'(dy);
      steep = ady > adx;
      sax   = steep ? stage_ff.y_start : stage_ff.x_start;
      say   = steep ? stage_ff.x_start : stage_ff.y_start;
      sbx   = steep ? stage_ff.y_end   : stage_ff.x_end;
      sby   = steep ? stage_ff.x_end   : stage_ff.y_end;
      swap_ends = sax > sbx;
      fax   = swap_ends ? sbx : sax;
      fay   = swap_ends ? sby : say;
      fby   = swap_ends ? say : sby;
   end

   // clip and rotate the current pixel
   always_comb begin
      lx  = steep_ff ? minor_pos_ff : major_pos_ff;
      ly  = steep_ff ? major_pos_ff : minor_pos_ff;
      lw  = rotation_ff[0] ? 12'(SCREEN_HEIGHT) : 12'(SCREEN_WIDTH);
      lh  = rotation_ff[0] ? 12'(SCREEN_WIDTH)  : 12'(SCREEN_HEIGHT);
      vis = !lx[11] && !ly[11] && ({1'b0, lx[10:0]} < lw) && ({1'b0, ly[10:0]} < lh);
      fin = major_pos_ff == major_end_ff;
      nx  = '0;
      ny  = '0;
      if (vis) begin
         unique case (rotation_ff)
            2'd1: begin
               nx = 12'(SCREEN_WIDTH - 1) - 12'(ly);
               ny = 12'(lx);
            end
            2'd2: begin
               nx = 12'(SCREEN_WIDTH - 1) - 12'(lx);
               ny = 12'(SCREEN_HEIGHT - 1) - 12'(ly);
            end
            2'd3: begin
               nx = 12'(ly);
               ny = 12'(SCREEN_HEIGHT - 1) - 12'(lx);
            end
            default: begin
               nx = 12'(lx);
               ny = 12'(ly);
            end
         endcase
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      steep_in      = steep_ff;
      major_pos_in  = major_pos_ff;
      major_end_in  = major_end_ff;
      minor_pos_in  = minor_pos_ff;
      minor_dir_in  = minor_dir_ff;
      major_span_in = major_span_ff;
      minor_span_in = minor_span_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      err_sub       = error_ff - $signed({1'b0, minor_span_ff});
      if (is_start) begin
         busy_in       = 1'b1;
         steep_in      = steep;
         major_pos_in  = fax;
         major_end_in  = swap_ends ? sax : sbx;
         minor_pos_in  = fay;
         // spans are symmetric under the endpoint swap
         major_span_in = steep ? ady : adx;
         minor_span_in = steep ? adx : ady;
         error_in      = $signed({1'b0, (steep ? ady : adx) >> 1});
         minor_dir_in  = !(fay < fby);
         color_in      = stage_ff.line_color;
      end else if (is_pixel) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + 12'sd1;
            if (err_sub[13]) begin
               minor_pos_in = minor_dir_ff ? minor_pos_ff - 12'sd1 : minor_pos_ff + 12'sd1;
               error_in     = err_sub + $signed({1'b0, major_span_ff});
            end else begin
               error_in = err_sub;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (is_pixel) begin
         rsp_valid_in       = 1'b1;
         rsp_in.native_x    = nx[7:0];
         rsp_in.native_y    = ny[8:0];
         rsp_in.pixel_color = color_ff;
         rsp_in.visible     = vis;
         rsp_in.last        = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rotation_ff    <= 2'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            rotation_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         stage_ff <= req_data;
      end
      steep_ff      <= steep_in;
      major_pos_ff  <= major_pos_in;
      major_end_ff  <= major_end_in;
      minor_pos_ff  <= minor_pos_in;
      minor_dir_ff  <= minor_dir_in;
      major_span_ff <= major_span_in;
      minor_span_ff <= minor_span_in;
      error_ff      <= error_in;
      color_ff      <= color_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      is_pixel && fin |=> !busy_ff)
      else $error("line still active after its last pixel");

   a_error_nonneg: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !error_ff[13])
      else $error("error term negative during a line");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.visible |-> rsp_ff.native_x == 8'd0 && rsp_ff.native_y == 9'd0)
      else $error("clipped pixel with nonzero coordinates");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      is_start |=> !rsp_valid_ff)
      else $error("start transaction produced a pixel");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("input stalled with the pipeline free");
`endif

endmodule

`default_nettype wire

// File: tb/line_pixel_rasterizer_tb.sv
// testbench for the line pixel rasterizer: directed and random lines checked against a line-walk predictor
module line_pixel_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpr_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_CHUNKS = 16;
   localparam int CHUNK_ITEMS   = 110;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   req_type    req_data         = '0;
   logic       rsp_stall        = 1'b0;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data   = ROT_0;
   logic       req_stall;
   logic       rsp_valid;
   rsp_type    rsp_data;

   // predictor state
   logic [1:0]  model_rotation;
   bit          line_active;
   bit          steep;
   bit          cross_down;
   int          walk_pos;
   int          walk_end;
   int          cross_pos;
   int          walk_span;
   int          cross_span;
   int          walk_err;
   logic [15:0] held_color;

   rsp_type     pixel_q[$];
   int          error_count  = 0;
   int          useful_items = 0;
   int          idle_cycles  = 0;
   int          burst_left   = 0;
   bit          no_gaps      = 1'b0;
   logic [1:0]  cur_rotation = ROT_0;
   int          stall_cycle  = 0;
   int          stall_mode   = 0;
   int          stall_run    = 0;

   line_pixel_rasterizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp12(input int v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return v;
   endfunction

   // mostly on the screen or just past its edges, sometimes anywhere in the 12-bit range
   function automatic int pick_coord(input int lim);
      case ($urandom_range(0, 3))
         0, 1: return int'($urandom_range(0, lim + 7)) - 4;
         2: return int'($urandom_range(0, lim - 1));
         default: return int'($urandom_range(0, 4095)) - 2048;
      endcase
   endfunction

   // walks the line one pixel per tick and queues the pixel it should produce
   function automatic void rasterize(input req_type item);
      int ax, ay, bx, by, t;
      int lx, ly, lw, lh, nx, ny;
      bit vis;
      rsp_type px;
      if (item.operation == OP_START) begin
         ax = item.x_start;
         ay = item.y_start;
         bx = item.x_end;
         by = item.y_end;
         steep = iabs(by - ay) > iabs(bx - ax);
         if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
         end
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
         walk_pos    = ax;
         walk_end    = bx;
         cross_pos   = ay;
         walk_span   = bx - ax;
         cross_span  = iabs(by - ay);
         walk_err    = walk_span / 2;
         cross_down  = !(ay < by);
         held_color  = item.line_color;
         line_active = 1'b1;
         useful_items++;
         return;
      end
      if (!line_active) return;
      useful_items++;
      lx  = steep ? cross_pos : walk_pos;
      ly  = steep ? walk_pos : cross_pos;
      lw  = model_rotation[0] ? SCREEN_HEIGHT : SCREEN_WIDTH;
      lh  = model_rotation[0] ? SCREEN_WIDTH : SCREEN_HEIGHT;
      vis = lx >= 0 && ly >= 0 && lx < lw && ly < lh;
      nx  = 0;
      ny  = 0;
      if (vis) begin
         case (model_rotation)
            ROT_90: begin
               nx = SCREEN_WIDTH - 1 - ly;
               ny = lx;
            end
            ROT_180: begin
               nx = SCREEN_WIDTH - 1 - lx;
               ny = SCREEN_HEIGHT - 1 - ly;
            end
            ROT_270: begin
               nx = ly;
               ny = SCREEN_HEIGHT - 1 - lx;
            end
            default: begin
               nx = lx;
               ny = ly;
            end
         endcase
      end
      px.native_x    = nx[7:0];
      px.native_y    = ny[8:0];
      px.pixel_color = held_color;
      px.visible     = vis;
      px.last        = (walk_pos == walk_end);
      pixel_q.push_back(px);
      if (px.last) begin
         line_active = 1'b0;
      end else begin
         walk_err -= cross_span;
         if (walk_err < 0) begin
            cross_pos += cross_down ? -1 : 1;
            walk_err  += walk_span;
         end
         walk_pos += 1;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   // predictor, pixel checker and idle watchdog all sample at the clock edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         model_rotation = ROT_0;
         line_active    = 1'b0;
         steep          = 1'b0;
         cross_down     = 1'b0;
         walk_pos       = 0;
         walk_end       = 0;
         cross_pos      = 0;
         walk_span      = 0;
         cross_span     = 0;
         walk_err       = 0;
         held_color     = '0;
         idle_cycles    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               report_mismatch("pixel with nothing expected", 1, 0);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.native_x !== want.native_x)
                  report_mismatch("native_x", rsp_data.native_x, want.native_x);
               if (rsp_data.native_y !== want.native_y)
                  report_mismatch("native_y", rsp_data.native_y, want.native_y);
               if (rsp_data.pixel_color !== want.pixel_color)
                  report_mismatch("pixel_color", rsp_data.pixel_color, want.pixel_color);
               if (rsp_data.visible !== want.visible)
                  report_mismatch("visible", rsp_data.visible, want.visible);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         if (csr_write_enable) model_rotation = csr_write_data;
         if (req_valid && !req_stall) rasterize(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver backpressure: free flow, random, periodic and long bursts, mode picked at random
   always @(posedge clock) begin : stall_pattern
      stall_cycle++;
      if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= (stall_cycle % 5 < 2);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // returns in the time step of the edge that accepted the transaction
   task automatic send_transaction(input req_type item);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_start(input int x0, input int y0, input int x1, input int y1,
                             input logic [15:0] color);
      req_type item;
      item.operation  = OP_START;
      item.x_start    = 12'(x0);
      item.y_start    = 12'(y0);
      item.x_end      = 12'(x1);
      item.y_end      = 12'(y1);
      item.line_color = color;
      send_transaction(item);
   endtask

   // endpoint fields are don't-care on a tick, so fill them with noise
   task automatic send_tick();
      req_type item;
      item.operation  = OP_TICK;
      item.x_start    = 12'($urandom);
      item.y_start    = 12'($urandom);
      item.x_end      = 12'($urandom);
      item.y_end      = 12'($urandom);
      item.line_color = 16'($urandom);
      send_transaction(item);
   endtask

   task automatic wait_pixels_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_rotation(input logic [1:0] rot);
      wait_pixels_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= rot;
      cur_rotation      = rot;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_corner_cases();
      send_tick();                                     // no line loaded yet
      send_start(10, 20, 10, 20, 16'hFFFF);            // single point
      send_tick();
      send_tick();                                     // line already finished
      send_start(-2048, 2047, 2047, -2048, 16'h0000);  // full range, off screen
      repeat (2) send_tick();
      send_start(3, 12, 0, 4, 16'hA5A5);               // steep, reversed, replaces active line
      repeat (9) send_tick();
      send_start(2, -1, -2, 1, 16'h5A5A);              // shallow, reversed, across the corner
      repeat (5) send_tick();
   endtask

   task automatic draw_random_line();
      int lw, lh, x0, y0, x1, y1, span, ticks;
      lw = cur_rotation[0] ? SCREEN_HEIGHT : SCREEN_WIDTH;
      lh = cur_rotation[0] ? SCREEN_WIDTH : SCREEN_HEIGHT;
      x0 = pick_coord(lw);
      y0 = pick_coord(lh);
      if ($urandom_range(0, 4) == 0) begin
         x1 = pick_coord(lw);
         y1 = pick_coord(lh);
      end else begin
         x1 = clamp12(x0 + int'($urandom_range(0, 40)) - 20);
         y1 = clamp12(y0 + int'($urandom_range(0, 40)) - 20);
      end
      span = (iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0);
      // long lines are cut short by the next start
      if (span > 60) begin
         ticks = $urandom_range(1, 40);
      end else begin
         case ($urandom_range(0, 6))
            0: ticks = $urandom_range(0, span);
            1: ticks = span + 1 + $urandom_range(1, 3);
            default: ticks = span + 1;
         endcase
      end
      send_start(x0, y0, x1, y1, 16'($urandom));
      repeat (ticks) send_tick();
   endtask

   task automatic send_noise();
      req_type item;
      item.operation  = op_type'($urandom_range(0, 1));
      item.x_start    = 12'($urandom);
      item.y_start    = 12'($urandom);
      item.x_end      = 12'($urandom);
      item.y_end      = 12'($urandom);
      item.line_color = 16'($urandom);
      send_transaction(item);
   endtask

   task automatic test_random_lines();
      int target;
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         if (chunk < 4) set_rotation(2'(chunk));
         else if (chunk == RANDOM_CHUNKS - 1) set_rotation(ROT_270);
         else set_rotation(2'($urandom_range(0, 3)));
         no_gaps = (chunk % 5 == 2);
         target  = useful_items + CHUNK_ITEMS;
         while (useful_items < target) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else draw_random_line();
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin : main
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_random_lines();
      wait_pixels_drained();
      repeat (8) @(posedge clock);
      if (pixel_q.size() != 0) report_mismatch("pixels never returned", 0, pixel_q.size());
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: line_pixel_rasterizer.f
sv/lpr_pkg.sv
sv/line_pixel_rasterizer.sv
tb/line_pixel_rasterizer_tb.sv
